[rtl/adec_pkg.sv]
// shared types, constants and lookup functions for the block decryptor
package adec_pkg;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } cipher_t;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } plain_t;

  typedef enum logic [2:0] {
    CFG_KEY_SIZE    = 3'd0,
    CFG_KEY_0_7     = 3'd1,
    CFG_KEY_8_15    = 3'd2,
    CFG_KEY_16_23   = 3'd3,
    CFG_KEY_24_31   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KS_128 = 2'd0,
    KS_192 = 2'd1,
    KS_256 = 2'd2
  } key_size_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_ROUND
  } dec_state_e;

  localparam int unsigned RkRows    = 15;
  localparam int unsigned RkRowBits = 128;
  localparam int unsigned RkAddrW   = 4;

  // round key store write, one row of four words
  typedef struct packed {
    logic                 en;
    logic [RkAddrW-1:0]   addr;
    logic [RkRowBits-1:0] data;
  } rk_wr_t;

  // key schedule status towards the round datapath
  typedef struct packed {
    logic       busy;
    logic [3:0] nr;
  } kexp_status_t;

  localparam logic [7:0] FWD_SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] rcon(input logic [3:0] idx);
    logic [7:0] r;
    unique case (idx)
      4'd0:    r = 8'h01;
      4'd1:    r = 8'h02;
      4'd2:    r = 8'h04;
      4'd3:    r = 8'h08;
      4'd4:    r = 8'h10;
      4'd5:    r = 8'h20;
      4'd6:    r = 8'h40;
      4'd7:    r = 8'h80;
      4'd8:    r = 8'h1b;
      4'd9:    r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] round_count(input logic [1:0] ks);
    logic [3:0] n;
    unique case (ks)
      KS_128:  n = 4'd10;
      KS_192:  n = 4'd12;
      default: n = 4'd14;
    endcase
    return n;
  endfunction

  function automatic logic [31:0] subst_word(input logic [31:0] x);
    return {FWD_SBOX[x[31:24]], FWD_SBOX[x[23:16]], FWD_SBOX[x[15:8]], FWD_SBOX[x[7:0]]};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] mul9(input logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a);
    a4 = xtime(a2);
    a8 = xtime(a4);
    return a8 ^ a;
  endfunction

  function automatic logic [7:0] mulb(input logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a);
    a4 = xtime(a2);
    a8 = xtime(a4);
    return a8 ^ a2 ^ a;
  endfunction

  function automatic logic [7:0] muld(input logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a);
    a4 = xtime(a2);
    a8 = xtime(a4);
    return a8 ^ a4 ^ a;
  endfunction

  function automatic logic [7:0] mule(input logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a);
    a4 = xtime(a2);
    a8 = xtime(a4);
    return a8 ^ a4 ^ a2;
  endfunction

endpackage

[rtl/adec_ram.sv]
// generic single write, single read ram with registered read data
module adec_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/adec_key_exp.sv]
// key registers and word-per-cycle key schedule expansion into the round key store
module adec_key_exp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_addr_i,
  input  logic [63:0]            cfg_wdata_i,
  output adec_pkg::rk_wr_t       rk_wr_o,
  output adec_pkg::kexp_status_t status_o
);

  logic [1:0]  key_size_q;
  logic [63:0] key_q [4];
  logic        busy_q, busy_d;
  logic [5:0]  i_q, i_d;
  logic [2:0]  j_q, j_d;
  logic [3:0]  rc_q, rc_d;
  logic [31:0] hist_q [8];
  logic [31:0] buf_q [3];
  logic        start;
  logic [3:0]  nr, nk;
  logic [5:0]  last;
  logic [31:0] w, t;
  logic [2:0]  nk_m1;

  assign start = cfg_we_i && (cfg_addr_i <= adec_pkg::CFG_KEY_24_31);
  assign nr    = adec_pkg::round_count(key_size_q);
  assign nk    = nr - 4'd6;
  assign nk_m1 = 3'(nk - 4'd1);
  assign last  = 6'({nr, 2'b00} + 6'd3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_size_q <= 2'd0;
      for (int k = 0; k < 4; k++) key_q[k] <= 64'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        adec_pkg::CFG_KEY_SIZE:  key_size_q <= cfg_wdata_i[1:0];
        adec_pkg::CFG_KEY_0_7:   key_q[0]   <= cfg_wdata_i;
        adec_pkg::CFG_KEY_8_15:  key_q[1]   <= cfg_wdata_i;
        adec_pkg::CFG_KEY_16_23: key_q[2]   <= cfg_wdata_i;
        adec_pkg::CFG_KEY_24_31: key_q[3]   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // next schedule word
  always_comb begin
    t = hist_q[0];
    if (i_q < {2'b00, nk}) begin
      w = i_q[0] ? key_q[i_q[2:1]][63:32] : key_q[i_q[2:1]][31:0];
    end else begin
      priority if (j_q == 3'd0) begin
        t = adec_pkg::subst_word({t[7:0], t[31:8]}) ^ {24'd0, adec_pkg::rcon(rc_q)};
      end else if (nk == 4'd8 && j_q == 3'd4) begin
        t = adec_pkg::subst_word(t);
      end
      w = hist_q[nk_m1] ^ t;
    end
  end

  always_comb begin
    busy_d = busy_q;
    i_d    = i_q;
    j_d    = j_q;
    rc_d   = rc_q;
    if (start) begin
      busy_d = 1'b1;
      i_d    = 6'd0;
      j_d    = 3'd0;
      rc_d   = 4'd0;
    end else if (busy_q) begin
      i_d = i_q + 6'd1;
      if (j_q == nk_m1) begin
        j_d = 3'd0;
        if (i_q >= {2'b00, nk}) rc_d = rc_q + 4'd1;
      end else begin
        j_d = j_q + 3'd1;
      end
      if (i_q == last) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      i_q    <= 6'd0;
      j_q    <= 3'd0;
      rc_q   <= 4'd0;
    end else begin
      busy_q <= busy_d;
      i_q    <= i_d;
      j_q    <= j_d;
      rc_q   <= rc_d;
    end
  end

  // history line and row assembly
  always_ff @(posedge clk_i) begin
    if (busy_q && !start) begin
      hist_q[0] <= w;
      for (int k = 1; k < 8; k++) hist_q[k] <= hist_q[k-1];
      if (i_q[1:0] != 2'd3) buf_q[i_q[1:0]] <= w;
    end
  end

  assign rk_wr_o.en   = busy_q && !start && (i_q[1:0] == 2'd3);
  assign rk_wr_o.addr = i_q[5:2];
  assign rk_wr_o.data = {w, buf_q[2], buf_q[1], buf_q[0]};

  assign status_o.busy = busy_q;
  assign status_o.nr   = nr;

endmodule

[rtl/adec_col_lane.sv]
// one column lane: inverse sub bytes, round key add and optional inverse mix
module adec_col_lane (
  input  logic [31:0] col_i,
  input  logic [31:0] rk_i,
  input  logic        mix_i,
  output logic [31:0] col_o
);

  logic [7:0] a [4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      a[r] = adec_pkg::INV_SBOX[col_i[8*r +: 8]] ^ rk_i[8*r +: 8];
    end
    for (int r = 0; r < 4; r++) begin
      if (mix_i) begin
        col_o[8*r +: 8] = adec_pkg::mule(a[r]) ^ adec_pkg::mulb(a[(r+1)%4])
                        ^ adec_pkg::muld(a[(r+2)%4]) ^ adec_pkg::mul9(a[(r+3)%4]);
      end else begin
        col_o[8*r +: 8] = a[r];
      end
    end
  end

endmodule

[rtl/aes_block_decrypt.sv]
// top level of the aes block decryptor
// aes inverse cipher for one 16-byte block with a 128, 192 or 256 bit key.
// after any write to key_size or a key register the schedule is rebuilt,
// one word a cycle, into a 15-row round key store, during which no word is
// accepted. a block is then processed in order: the last round key is fetched,
// the initial key add is done, then each inverse round runs through four
// column lanes sharing the store's single read port. the result sits in an
// output register so the next word can be taken while it waits; a block is
// only held back once that register is still full at its final round. key
// size code 3 behaves as a 256-bit key.
module aes_block_decrypt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_addr_i,
  input  logic [63:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  adec_pkg::cipher_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output adec_pkg::plain_t  out_data_o
);

  adec_pkg::rk_wr_t       rk_wr;
  adec_pkg::kexp_status_t ks;
  adec_pkg::dec_state_e   st_q, st_d;

  logic [127:0] blk_q, blk_d;
  logic [3:0]   rnd_q, rnd_d;
  logic [127:0] rk_row;
  logic [127:0] shifted, lanes_out;
  logic         out_valid_q, out_valid_d;
  adec_pkg::plain_t out_q;
  logic         out_free, in_acc, out_load;

  adec_key_exp u_kexp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .rk_wr_o  (rk_wr),
    .status_o (ks)
  );

  // round key store, one row per round
  adec_ram #(
    .Width (adec_pkg::RkRowBits),
    .Depth (adec_pkg::RkRows)
  ) u_rk_ram (
    .clk_i,
    .we_i    (rk_wr.en),
    .waddr_i (rk_wr.addr),
    .wdata_i (rk_wr.data),
    .raddr_i (rnd_d),
    .rdata_o (rk_row)
  );

  // merge stage: inverse shift rows gathers each lane's column
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        shifted[32*c + 8*r +: 8] = blk_q[32*((c - r + 4) % 4) + 8*r +: 8];
      end
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_lane
    adec_col_lane u_lane (
      .col_i (shifted[32*c +: 32]),
      .rk_i  (rk_row[32*c +: 32]),
      .mix_i (rnd_q != 4'd0),
      .col_o (lanes_out[32*c +: 32])
    );
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (st_q == adec_pkg::ST_IDLE) && !ks.busy;
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (st_q == adec_pkg::ST_ROUND) && (rnd_q == 4'd0) && out_free;

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      adec_pkg::ST_IDLE:  if (in_acc) st_d = adec_pkg::ST_ADD;
      adec_pkg::ST_ADD:   st_d = adec_pkg::ST_ROUND;
      adec_pkg::ST_ROUND: if (out_load) st_d = adec_pkg::ST_IDLE;
      default:            st_d = adec_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    blk_d = blk_q;
    rnd_d = rnd_q;
    unique case (st_q)
      adec_pkg::ST_IDLE: begin
        if (in_acc) begin
          blk_d = in_data_i;
          rnd_d = ks.nr;
        end
      end
      adec_pkg::ST_ADD: begin
        blk_d = blk_q ^ rk_row;
        rnd_d = rnd_q - 4'd1;
      end
      adec_pkg::ST_ROUND: begin
        // final round stalls on a full output register
        if (rnd_q != 4'd0) begin
          blk_d = lanes_out;
          rnd_d = rnd_q - 4'd1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (out_load)    out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= adec_pkg::ST_IDLE;
      rnd_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    if (out_load) out_q <= lanes_out;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[tb/tb.sv]
// self-checking testbench for the aes block decryptor
`timescale 1ns / 100ps

module tb;

  // expected plaintext words in order of acceptance, predicted from the key schedule
  class plain_board;
    adec_pkg::plain_t pending_q[$];
    int     n_errors;

    function void note_cipher(adec_pkg::plain_t p);
      pending_q.push_back(p);
    endfunction

    function void check_plain(adec_pkg::plain_t got);
      adec_pkg::plain_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected plaintext word %h", $realtime, got);
        n_errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.plain_low !== want.plain_low) begin
        $display("%0t: plain_low expected %h actual %h", $realtime, want.plain_low,
                 got.plain_low);
        n_errors++;
      end
      if (got.plain_high !== want.plain_high) begin
        $display("%0t: plain_high expected %h actual %h", $realtime, want.plain_high,
                 got.plain_high);
        n_errors++;
      end
    endfunction
  endclass

  localparam int unsigned WatchLimit = 4000;
  localparam int unsigned ScheduleWait = 80;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [2:0]        cfg_addr_i;
  logic [63:0]       cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  adec_pkg::cipher_t in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  adec_pkg::plain_t  out_data_o;

  aes_block_decrypt u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  plain_board  board;
  // local copy of the configuration and the expanded schedule
  logic [1:0]  ks_reg;
  logic [63:0] key_reg [4];
  logic [31:0] sched [60];
  bit          calm;       // no idling in the final stretch
  bit          hold_rx;    // long receiver hold-off request
  int unsigned idle_cycles;
  bit          timed_out;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // ---------------- predictor ----------------
  function automatic int unsigned rounds_of(logic [1:0] ks);
    if (ks == adec_pkg::KS_128) return 10;
    if (ks == adec_pkg::KS_192) return 12;
    return 14;
  endfunction

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  function automatic logic [31:0] sbox_word(logic [31:0] x);
    logic [31:0] r;
    for (int k = 0; k < 4; k++) r[8*k +: 8] = adec_pkg::FWD_SBOX[x[8*k +: 8]];
    return r;
  endfunction

  // rebuild the schedule as the block does after every register write
  task automatic rebuild_schedule();
    int unsigned nr, nk, total;
    logic [31:0] t;
    logic [7:0]  rc;
    nr = rounds_of(ks_reg);
    nk = nr - 6;
    total = (nr + 1) * 4;
    for (int i = 0; i < nk; i++) sched[i] = key_reg[i/2][32*(i%2) +: 32];
    for (int i = nk; i < total; i++) begin
      t = sched[i-1];
      if (i % nk == 0) begin
        rc = 8'h01;
        for (int j = 1; j < i / nk; j++) rc = gmul(rc, 8'h02);
        t = sbox_word({t[7:0], t[31:8]}) ^ {24'd0, rc};
      end else if (nk == 8 && i % nk == 4) begin
        t = sbox_word(t);
      end
      sched[i] = sched[i-nk] ^ t;
    end
  endtask

  function automatic adec_pkg::plain_t decrypt_block(adec_pkg::cipher_t c);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a [4];
    int unsigned nr;
    adec_pkg::plain_t p;
    nr = rounds_of(ks_reg);
    for (int i = 0; i < 8; i++) begin
      s[i]   = c.cipher_low[8*i +: 8];
      s[i+8] = c.cipher_high[8*i +: 8];
    end
    for (int r = nr; r >= 0; r--) begin
      if (r != nr) begin
        // inverse shift rows and inverse sub bytes
        for (int col = 0; col < 4; col++)
          for (int row = 0; row < 4; row++)
            t[col*4+row] = adec_pkg::INV_SBOX[s[((col - row + 4) % 4)*4 + row]];
        s = t;
      end
      for (int col = 0; col < 4; col++)
        for (int k = 0; k < 4; k++) s[col*4+k] ^= sched[r*4+col][8*k +: 8];
      if (r != nr && r != 0) begin
        for (int col = 0; col < 4; col++) begin
          for (int k = 0; k < 4; k++) a[k] = s[col*4+k];
          for (int k = 0; k < 4; k++)
            s[col*4+k] = gmul(a[k], 8'h0e) ^ gmul(a[(k+1)%4], 8'h0b)
                       ^ gmul(a[(k+2)%4], 8'h0d) ^ gmul(a[(k+3)%4], 8'h09);
        end
      end
    end
    for (int i = 0; i < 8; i++) begin
      p.plain_low[8*i +: 8]  = s[i];
      p.plain_high[8*i +: 8] = s[i+8];
    end
    return p;
  endfunction

  // ---------------- drivers ----------------
  // a register write only happens with the block idle; the enable stays up
  // and the caller drops it after the last write
  task automatic write_reg(adec_pkg::cfg_idx_e idx, logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == adec_pkg::CFG_KEY_SIZE) ks_reg = val[1:0];
    else key_reg[idx - 1] = val;
    rebuild_schedule();
  endtask

  task automatic send_word(adec_pkg::cipher_t c);
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_cipher(decrypt_block(c));
  endtask

  // occasional sender gap, valid low between words
  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (ScheduleWait) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic adec_pkg::cipher_t rand_cipher();
    adec_pkg::cipher_t c;
    case ($urandom_range(0, 5))
      0:       c = '0;
      1:       c = '1;
      2:       c = {rand64(), 64'd0};
      default: c = {rand64(), rand64()};
    endcase
    return c;
  endfunction

  // write the whole key, then the size
  task automatic load_key(logic [1:0] ks, logic [63:0] k0, logic [63:0] k1,
                          logic [63:0] k2, logic [63:0] k3);
    write_reg(adec_pkg::CFG_KEY_0_7, k0);
    write_reg(adec_pkg::CFG_KEY_8_15, k1);
    write_reg(adec_pkg::CFG_KEY_16_23, k2);
    write_reg(adec_pkg::CFG_KEY_24_31, k3);
    write_reg(adec_pkg::CFG_KEY_SIZE, ks);
    cfg_we_i <= 1'b0;
    repeat (ScheduleWait) @(posedge clk_i);
  endtask

  // ---------------- receiver ----------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_plain(out_data_o);
  end

  // ready stalls in bursts, plus one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_rx) begin
        out_ready_i <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_rx = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  initial begin
    board       = new();
    calm        = 1'b0;
    hold_rx     = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    ks_reg      = adec_pkg::KS_128;
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: the standard 128-bit vector, then extremes for every key size
    load_key(adec_pkg::KS_128, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908, '0, '0);
    send_word({64'h5ac5b47080b7cdd8, 64'h30047b6ad8e0c469});
    send_word('0);
    send_word('1);
    drain();
    load_key(adec_pkg::KS_192, '1, '1, '1, '0);
    send_word('0);
    send_word('1);
    send_word({64'h8000000000000000, 64'h0000000000000001});
    drain();
    load_key(adec_pkg::KS_256, '0, '0, '0, '0);
    send_word('1);
    send_word('0);
    drain();
    load_key(adec_pkg::KS_256, '1, '1, '1, '1);
    send_word('0);
    send_word('1);
    drain();
    // key size code three behaves as a 256-bit key
    load_key(2'd3, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
             64'h1716151413121110, 64'h1f1e1d1c1b1a1918);
    send_word({64'h8960494b9049fcea, 64'h8ea2b7ca516745bf});
    send_word(rand_cipher());
    drain();

    // random phases, each with a fresh key and size
    for (int ph = 0; ph < 10; ph++) begin
      load_key($urandom_range(0, 3), rand64(), rand64(), rand64(), rand64());
      if (ph == 2) hold_rx = 1'b1;   // output held back while words keep coming
      if (ph == 9) calm = 1'b1;
      for (int n = 0; n < 100; n++) begin
        send_word(rand_cipher());
        maybe_gap();
        // sender waits for every result once
        if (ph == 4 && n == 50) begin
          in_valid_i <= 1'b0;
          while (board.pending_q.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    if (board.n_errors == 0 && board.pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
